>>> rtl/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared widths, byte-class constants and the result type of the UTF-8 to
// UTF-32 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

   localparam int BYTE_WIDTH    = 8;
   localparam int CP_WIDTH      = 21;
   localparam int PENDING_WIDTH = 2;

   // continuation bytes carry six payload bits
   localparam int CONT_BITS = 6;

   // top two bits of a continuation byte
   localparam logic [1:0] CONT_TAG = 2'b10;

   // sequence lengths, as continuation bytes still expected after the lead
   localparam logic [PENDING_WIDTH-1:0] PEND_NONE  = 2'd0;
   localparam logic [PENDING_WIDTH-1:0] PEND_ONE   = 2'd1;
   localparam logic [PENDING_WIDTH-1:0] PEND_TWO   = 2'd2;
   localparam logic [PENDING_WIDTH-1:0] PEND_THREE = 2'd3;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                error;
      logic                end_of_string;
   } result_type;

endpackage

>>> rtl/u8dec_req_if.sv
// ----------------------------------------------------------------------------
// u8dec_req_if
// Byte channel into the decoder: one raw byte and a last-byte flag per item.
// ----------------------------------------------------------------------------
interface u8dec_req_if
   import u8dec_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] byte_in;
   logic                  last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

>>> rtl/u8dec_rsp_if.sv
// ----------------------------------------------------------------------------
// u8dec_rsp_if
// Result channel out of the decoder: one code point or error per item.
// ----------------------------------------------------------------------------
interface u8dec_rsp_if
   import u8dec_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CP_WIDTH-1:0] code_point;
   logic                error;
   logic                end_of_string;

   modport source (output valid, output code_point, output error,
                   output end_of_string, input ready);
   modport sink   (input valid, input code_point, input error,
                   input end_of_string, output ready);
endinterface

>>> rtl/utf8_to_utf32_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_core
// Streaming UTF-8 decoder: takes one byte per item and emits a 21-bit code
// point when a sequence completes, or one error item that ends the string.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake      payload
//   req_if   in         valid / ready  byte_in[7:0], last_byte
//   rsp_if   out        valid / ready  code_point[20:0], error, end_of_string
//
// One byte is accepted per cycle unless a result stalls; each byte passes
// an input register, one decode step against the sequence state, and the
// result register, from which its result is offered on rsp_if.
// The input register is freed whenever its byte makes no result or the
// result register is empty or being drained, so throughput is one byte per
// cycle while rsp_if.ready stays high.
// Synchronous active-high reset clears the valid flags and sequence state.
//
module utf8_to_utf32_decoder_core
   import u8dec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   u8dec_req_if.sink    req_if,
   u8dec_rsp_if.source  rsp_if
);

   // input register
   logic                     in_valid_ff;
   logic [BYTE_WIDTH-1:0]    in_byte_ff;
   logic                     in_last_ff;

   // sequence state
   logic [PENDING_WIDTH-1:0] pending_ff, pending_in;
   logic [CP_WIDTH-1:0]      partial_ff, partial_in;
   logic                     skipping_ff, skipping_in;

   // result register
   logic                     out_valid_ff, out_valid_in;
   result_type               out_ff;

   // decode step
   logic                     emit;
   result_type               result;
   logic [CP_WIDTH-1:0]      shifted;
   logic                     advance;

   // Decode the byte in the input register against the sequence state
   always_comb begin
      emit        = 1'b0;
      result      = '0;
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      skipping_in = skipping_ff;
      shifted     = {partial_ff[CP_WIDTH-CONT_BITS-1:0], in_byte_ff[CONT_BITS-1:0]};

      if (skipping_ff) begin
         // drop bytes through the string's last byte
         if (in_last_ff) begin
            skipping_in = 1'b0;
         end
      end else if (pending_ff != PEND_NONE) begin
         if (in_byte_ff[7:6] != CONT_TAG) begin
            emit                 = 1'b1;
            result.error         = 1'b1;
         end else begin
            pending_in = pending_ff - PEND_ONE;
            partial_in = shifted;
            if (pending_ff == PEND_ONE) begin
               emit                 = 1'b1;
               result.code_point    = shifted;
               result.end_of_string = in_last_ff;
            end else if (in_last_ff) begin
               // string ends mid-sequence
               emit         = 1'b1;
               result.error = 1'b1;
            end
         end
      end else if (!in_byte_ff[7]) begin
         emit                 = 1'b1;
         result.code_point    = CP_WIDTH'(in_byte_ff[6:0]);
         result.end_of_string = in_last_ff;
      end else if (!in_byte_ff[6]) begin
         // stray continuation
         emit         = 1'b1;
         result.error = 1'b1;
      end else begin
         // open a multi-byte sequence
         if (!in_byte_ff[5]) begin
            pending_in = PEND_ONE;
            partial_in = CP_WIDTH'(in_byte_ff[4:0]);
         end else if (!in_byte_ff[4]) begin
            pending_in = PEND_TWO;
            partial_in = CP_WIDTH'(in_byte_ff[3:0]);
         end else if (!in_byte_ff[3]) begin
            pending_in = PEND_THREE;
            partial_in = CP_WIDTH'(in_byte_ff[2:0]);
         end else begin
            emit         = 1'b1;
            result.error = 1'b1;
         end
         if (in_last_ff) begin
            emit         = 1'b1;
            result.error = 1'b1;
         end
      end

      // an error ends the string and clears the sequence
      if (result.error) begin
         result.code_point    = '0;
         result.end_of_string = 1'b1;
         pending_in           = PEND_NONE;
         partial_in           = '0;
         skipping_in          = !in_last_ff;
      end else if (emit) begin
         pending_in = PEND_NONE;
         partial_in = '0;
      end
   end

   // Advance the input register when its byte makes no result or the result has room
   assign advance      = in_valid_ff && (!emit || !out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_if.ready);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pending_ff   <= PEND_NONE;
         partial_ff   <= '0;
         skipping_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            pending_ff  <= pending_in;
            partial_ff  <= partial_in;
            skipping_ff <= skipping_in;
         end
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_byte_ff <= req_if.byte_in;
         in_last_ff <= req_if.last_byte;
      end
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.code_point    = out_ff.code_point;
   assign rsp_if.error         = out_ff.error;
   assign rsp_if.end_of_string = out_ff.end_of_string;

`ifndef SYNTHESIS
   // an error item always ends its string with a zero code point
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.error |-> out_ff.end_of_string && out_ff.code_point == '0)
      else $error("error item without end_of_string or with nonzero code point");

   // skipping never coexists with an open sequence
   assert property (@(posedge clock) disable iff (reset)
      skipping_ff |-> pending_ff == PEND_NONE && partial_ff == '0)
      else $error("skipping with an open sequence");

   // dropped bytes make no result
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && skipping_ff |-> !emit)
      else $error("result made while skipping");

   // a stalled result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |-> !(advance && emit))
      else $error("result register overwritten during stall");

   // a result follows the advance of a byte that makes one
   assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> out_valid_ff)
      else $error("result lost after advance");
`endif

endmodule
